### hw/rtl/afuv_pkg.sv
package afuv_pkg;

  localparam int MaxRows   = 8;
  localparam int FracBits  = 16;
  localparam int UvW       = FracBits + 1;
  localparam int RowW      = 3;
  localparam int ColW      = 8;
  localparam int TotW      = 11;
  localparam int DivSteps  = 4;
  localparam int DivStages = 5;
  localparam int QuoW      = DivSteps * DivStages;
  localparam logic [UvW-1:0]  OneQ     = UvW'(1) << FracBits;
  localparam logic [QuoW-1:0] Dividend = QuoW'(OneQ);

  typedef enum logic [1:0] {
    REG_TILES_Y   = 2'd0,
    REG_ROWS_DEF  = 2'd1,
    REG_ROW_COLS  = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]         tiles_y;
    logic [3:0]         rows_defined;
    logic [63:0]        row_cols;
  } cfg_t;

  // front end to divider
  typedef struct packed {
    logic            valid;
    logic            zero;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [7:0]      cols;
    logic [7:0]      ty;
  } sel_t;

  // divider to output stage
  typedef struct packed {
    logic            valid;
    logic            zero;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [UvW-1:0]  su;
    logic [UvW-1:0]  sv;
  } quo_t;

  typedef struct packed {
    logic [7:0]          rem;
    logic [DivSteps-1:0] q;
  } div_part_t;

  // DivSteps restoring division steps; rem stays below d
  function automatic div_part_t div_chunk(input logic [7:0] rem_in,
                                          input logic [DivSteps-1:0] bits,
                                          input logic [7:0] d);
    div_part_t  res;
    logic [8:0] r;
    res.rem = rem_in;
    res.q   = '0;
    for (int i = DivSteps - 1; i >= 0; i--) begin
      r = {res.rem, bits[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        res.q[i] = 1'b1;
      end
      res.rem = r[7:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/afuv_cfg.sv
module afuv_cfg
  import afuv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[4:3]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tiles_y      <= 8'd1;
      cfg_r.rows_defined <= 4'd1;
      cfg_r.row_cols     <= 64'd1;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_TILES_Y:  cfg_r.tiles_y      <= pwdata[7:0];
        REG_ROWS_DEF: cfg_r.rows_defined <= pwdata[3:0];
        REG_ROW_COLS: cfg_r.row_cols     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TILES_Y:  prdata = {56'd0, cfg_r.tiles_y};
      REG_ROWS_DEF: prdata = {60'd0, cfg_r.rows_defined};
      REG_ROW_COLS: prdata = cfg_r.row_cols;
      default:      prdata = '0;
    endcase
  end

endmodule

### hw/rtl/afuv_front.sv
module afuv_front
  import afuv_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [UvW-1:0] in_progress,
  input  cfg_t           cfg,
  output sel_t           sel
);

  // stage 1: saturate, mask unused rows
  logic                v1_r;
  logic [UvW-1:0]      p1_r;
  logic [7:0]          cnt1_r [MaxRows];
  logic [7:0]          ty1_r;
  logic                z1_r;
  // stage 2: prefix sums
  logic                v2_r;
  logic [UvW-1:0]      p2_r;
  logic [7:0]          cnt2_r [MaxRows];
  logic [TotW-1:0]     pre2_r [MaxRows];
  logic [TotW-1:0]     tot2_r;
  logic [7:0]          ty2_r;
  logic                z2_r;
  // stage 3: frame index
  logic                v3_r;
  logic [7:0]          cnt3_r [MaxRows];
  logic [TotW-1:0]     pre3_r [MaxRows];
  logic [TotW-1:0]     frm3_r;
  logic [7:0]          ty3_r;
  logic                z3_r;
  // stage 4: row and column
  sel_t                sel_r;

  logic [7:0]          ty_eff;
  logic [3:0]          rd_sat;
  logic [8:0]          rows;
  logic [TotW-1:0]     pre_nxt [MaxRows];
  logic [TotW-1:0]     tot_nxt;
  logic [UvW+TotW-1:0] prod;
  logic [TotW:0]       frm_raw;
  logic [TotW-1:0]     frm_nxt;
  logic [RowW-1:0]     row_nxt;

  always_comb begin
    ty_eff = (cfg.tiles_y == 8'd0) ? 8'd1 : cfg.tiles_y;
    rd_sat = (cfg.rows_defined > 4'(MaxRows)) ? 4'(MaxRows) : cfg.rows_defined;
    rows   = ({1'b0, ty_eff} < {5'd0, rd_sat}) ? {1'b0, ty_eff} : {5'd0, rd_sat};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      sel_r.valid <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      sel_r.valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r  <= (in_progress > OneQ) ? OneQ : in_progress;
    ty1_r <= ty_eff;
    z1_r  <= (rows == 9'd0);
    for (int y = 0; y < MaxRows; y++) begin
      if (9'(y) < rows)
        cnt1_r[y] <= (cfg.row_cols[8*y +: 8] == 8'd0) ? 8'd1 : cfg.row_cols[8*y +: 8];
      else
        cnt1_r[y] <= 8'd0;
    end
  end

  always_comb begin
    pre_nxt[0] = '0;
    for (int y = 1; y < MaxRows; y++)
      pre_nxt[y] = pre_nxt[y-1] + TotW'(cnt1_r[y-1]);
    tot_nxt = pre_nxt[MaxRows-1] + TotW'(cnt1_r[MaxRows-1]);
  end

  always_ff @(posedge clk) begin
    p2_r   <= p1_r;
    cnt2_r <= cnt1_r;
    pre2_r <= pre_nxt;
    tot2_r <= tot_nxt;
    ty2_r  <= ty1_r;
    z2_r   <= z1_r;
  end

  always_comb begin
    prod    = (UvW+TotW)'(p2_r) * (UvW+TotW)'(tot2_r);
    frm_raw = prod[FracBits +: TotW+1];
    if (z2_r)
      frm_nxt = '0;
    else if (frm_raw > {1'b0, tot2_r - TotW'(1)})
      frm_nxt = tot2_r - TotW'(1);
    else
      frm_nxt = frm_raw[TotW-1:0];
  end

  always_ff @(posedge clk) begin
    cnt3_r <= cnt2_r;
    pre3_r <= pre2_r;
    frm3_r <= frm_nxt;
    ty3_r  <= ty2_r;
    z3_r   <= z2_r;
  end

  // unused rows have zero width, so their start never lies at or below the frame
  always_comb begin
    row_nxt = '0;
    for (int y = 1; y < MaxRows; y++)
      if (pre3_r[y] <= frm3_r && cnt3_r[y] != 8'd0)
        row_nxt = RowW'(y);
  end

  always_ff @(posedge clk) begin
    sel_r.zero <= z3_r;
    sel_r.row  <= z3_r ? '0 : row_nxt;
    sel_r.col  <= z3_r ? '0 : ColW'(frm3_r - pre3_r[row_nxt]);
    sel_r.cols <= z3_r ? 8'd1 : cnt3_r[row_nxt];
    sel_r.ty   <= ty3_r;
  end

  assign sel = sel_r;

endmodule

### hw/rtl/afuv_div.sv
module afuv_div
  import afuv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sel_t sel,
  output quo_t quo
);

  sel_t              sb_r   [DivStages];
  logic [7:0]        remu_r [DivStages];
  logic [7:0]        remv_r [DivStages];
  logic [QuoW-1:0]   qu_r   [DivStages];
  logic [QuoW-1:0]   qv_r   [DivStages];

  genvar s;
  generate
    for (s = 0; s < DivStages; s++) begin : g_stage
      sel_t            sb_in;
      logic [7:0]      ru_in, rv_in;
      logic [QuoW-1:0] qu_in, qv_in;
      div_part_t       pu, pv;

      if (s == 0) begin : g_first
        assign sb_in = sel;
        assign ru_in = '0;
        assign rv_in = '0;
        assign qu_in = '0;
        assign qv_in = '0;
      end else begin : g_rest
        assign sb_in = sb_r[s-1];
        assign ru_in = remu_r[s-1];
        assign rv_in = remv_r[s-1];
        assign qu_in = qu_r[s-1];
        assign qv_in = qv_r[s-1];
      end

      assign pu = div_chunk(ru_in, Dividend[QuoW-1-DivSteps*s -: DivSteps], sb_in.cols);
      assign pv = div_chunk(rv_in, Dividend[QuoW-1-DivSteps*s -: DivSteps], sb_in.ty);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sb_r[s].valid <= 1'b0;
        end else begin
          sb_r[s].valid <= sb_in.valid;
        end
      end

      always_ff @(posedge clk) begin
        sb_r[s].zero <= sb_in.zero;
        sb_r[s].row  <= sb_in.row;
        sb_r[s].col  <= sb_in.col;
        sb_r[s].cols <= sb_in.cols;
        sb_r[s].ty   <= sb_in.ty;
        remu_r[s] <= pu.rem;
        remv_r[s] <= pv.rem;
        qu_r[s]   <= qu_in | (QuoW'(pu.q) << (QuoW - DivSteps*(s+1)));
        qv_r[s]   <= qv_in | (QuoW'(pv.q) << (QuoW - DivSteps*(s+1)));
      end
    end
  endgenerate

  assign quo.valid = sb_r[DivStages-1].valid;
  assign quo.zero  = sb_r[DivStages-1].zero;
  assign quo.row   = sb_r[DivStages-1].row;
  assign quo.col   = sb_r[DivStages-1].col;
  assign quo.su    = qu_r[DivStages-1][UvW-1:0];
  assign quo.sv    = qv_r[DivStages-1][UvW-1:0];

endmodule

### hw/rtl/flipbook_atlas_frame_uv.sv
// Flipbook atlas frame selector. Pulse start with in_progress (Q1.16, values
// above 1.0 saturate); busy is always low, so a word may be started on every
// cycle. For each word, out_valid is later high for one cycle with the
// frame's UV scale/offset and row/column; there is no way to hold results
// off, so the receiver must take every word as it appears. Each word passes
// through the pipeline: four stages for row sums, frame index and row
// search, five stages of a 4-bit-per-stage reciprocal divider for 1/columns
// and 1/tiles_y, and one stage for the offset multiplies. Registers sit on
// a 64-bit APB-style port at byte offsets 0 (tiles_y), 8 (rows_defined),
// 16 (row_columns_packed); change them only with no word in flight.
module flipbook_atlas_frame_uv
  import afuv_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  // command channel
  input  logic            start,
  output logic            busy,
  input  logic [UvW-1:0]  in_progress,
  // results
  output logic            out_valid,
  output logic [UvW-1:0]  out_scale_u,
  output logic [UvW-1:0]  out_scale_v,
  output logic [UvW-1:0]  out_offset_u,
  output logic [UvW-1:0]  out_offset_v,
  output logic [RowW-1:0] out_row_number,
  output logic [ColW-1:0] out_column_number,
  // configuration
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [63:0]     pwdata,
  output logic [63:0]     prdata,
  output logic            pready
);

  cfg_t cfg;
  sel_t sel;
  quo_t quo;

  logic                valid_r;
  logic [UvW-1:0]      su_r, sv_r, ou_r, ov_r;
  logic [RowW-1:0]     row_r;
  logic [ColW-1:0]     col_r;
  logic [UvW+ColW-1:0] ou_full;
  logic [UvW+RowW-1:0] ov_full;

  // fully pipelined, never stalls
  assign busy = 1'b0;

  afuv_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  afuv_front u_front (
    .clk, .rst_n, .in_valid(start), .in_progress, .cfg, .sel
  );

  afuv_div u_div (
    .clk, .rst_n, .sel, .quo
  );

  // offsets: column * scale_u, row * scale_v, kept to the UV width
  assign ou_full = (UvW+ColW)'(quo.col) * (UvW+ColW)'(quo.su);
  assign ov_full = (UvW+RowW)'(quo.row) * (UvW+RowW)'(quo.sv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= quo.valid;
    end
  end

  always_ff @(posedge clk) begin
    // no rows in use: unit scale, zero offset, row and column zero
    su_r  <= quo.zero ? OneQ : quo.su;
    sv_r  <= quo.zero ? OneQ : quo.sv;
    ou_r  <= quo.zero ? '0 : ou_full[UvW-1:0];
    ov_r  <= quo.zero ? '0 : ov_full[UvW-1:0];
    row_r <= quo.row;
    col_r <= quo.col;
  end

  assign out_valid         = valid_r;
  assign out_scale_u       = su_r;
  assign out_scale_v       = sv_r;
  assign out_offset_u      = ou_r;
  assign out_offset_v      = ov_r;
  assign out_row_number    = row_r;
  assign out_column_number = col_r;

endmodule

### dv/tb.sv
module tb;
  import afuv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // frame-select word as the testbench sees it
  typedef struct {
    logic [UvW-1:0]  su;
    logic [UvW-1:0]  sv;
    logic [UvW-1:0]  ou;
    logic [UvW-1:0]  ov;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } uv_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [UvW-1:0] in_progress = '0;
  logic out_valid;
  logic [UvW-1:0] out_scale_u, out_scale_v, out_offset_u, out_offset_v;
  logic [RowW-1:0] out_row_number;
  logic [ColW-1:0] out_column_number;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  flipbook_atlas_frame_uv DUT (
    .clk, .rst_n, .start, .busy, .in_progress,
    .out_valid, .out_scale_u, .out_scale_v, .out_offset_u, .out_offset_v,
    .out_row_number, .out_column_number,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // shadow copy of the atlas registers
  logic [7:0]  atlas_tiles_y = 8'd1;
  logic [3:0]  atlas_rows_def = 4'd1;
  logic [63:0] atlas_row_cols = 64'd1;

  logic [UvW-1:0] progress_q[$];   // words waiting to be started
  uv_word_t       frame_uv_q[$];   // expected result words, oldest first
  int             send_idle_pct = 0;
  int             n_errors = 0;

  function automatic logic [8:0] row_width(input int r);
    logic [7:0] c;
    c = atlas_row_cols[r*8 +: 8];
    return (c == 8'd0) ? 9'd1 : {1'b0, c};
  endfunction

  // atlas lookup: frame index from progress, then row walk
  function automatic uv_word_t atlas_lookup(input logic [UvW-1:0] prog);
    uv_word_t w;
    logic [8:0] ty, rd, rows;
    logic [31:0] p, total, frame, rem, cols;
    int r, c;
    ty = (atlas_tiles_y == 8'd0) ? 9'd1 : {1'b0, atlas_tiles_y};
    rd = (atlas_rows_def > MaxRows) ? 9'(MaxRows) : {5'd0, atlas_rows_def};
    rows = (ty < rd) ? ty : rd;
    p = (prog > OneQ) ? 32'(OneQ) : 32'(prog);
    if (rows == 0) begin
      w.su = OneQ; w.sv = OneQ; w.ou = '0; w.ov = '0; w.row = '0; w.col = '0;
      return w;
    end
    total = 0;
    for (int y = 0; y < rows; y++) total += row_width(y);
    frame = (p * total) >> FracBits;
    if (frame > total - 1) frame = total - 1;
    rem = frame; r = 0; c = 0;
    for (int y = 0; y < rows; y++) begin
      if (rem < row_width(y)) begin
        r = y; c = rem;
        break;
      end
      rem -= row_width(y);
    end
    cols = row_width(r);
    w.su = UvW'(32'(OneQ) / cols);
    w.sv = UvW'(32'(OneQ) / ty);
    w.ou = UvW'(c * w.su);
    w.ov = UvW'(r * w.sv);
    w.row = RowW'(r);
    w.col = ColW'(c);
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // driver: start a word when the queue has one and the idle roll allows
  always @(posedge clk) begin
    if (rst_n && progress_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      start <= 1'b1;
      in_progress <= progress_q[0];
      frame_uv_q.push_back(atlas_lookup(progress_q[0]));
      void'(progress_q.pop_front());
    end else begin
      start <= 1'b0;
      in_progress <= UvW'($urandom);
    end
  end

  // monitor: busy is never high, so every started word gets one result
  always @(posedge clk) begin
    uv_word_t w;
    if (rst_n && out_valid) begin
      if (frame_uv_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        w = frame_uv_q.pop_front();
        if (out_scale_u !== w.su) report_mismatch("scale_u", out_scale_u, w.su);
        if (out_scale_v !== w.sv) report_mismatch("scale_v", out_scale_v, w.sv);
        if (out_offset_u !== w.ou) report_mismatch("offset_u", out_offset_u, w.ou);
        if (out_offset_v !== w.ov) report_mismatch("offset_v", out_offset_v, w.ov);
        if (out_row_number !== w.row) report_mismatch("row", out_row_number, w.row);
        if (out_column_number !== w.col)
          report_mismatch("column", out_column_number, w.col);
      end
    end
  end

  // APB write: setup then access, shadow updated at the same edge
  task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 3; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_TILES_Y:  atlas_tiles_y = val[7:0];
      REG_ROWS_DEF: atlas_rows_def = val[3:0];
      REG_ROW_COLS: atlas_row_cols = val;
      default: ;
    endcase
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drain the pipeline before touching registers
  task automatic wait_drained();
    while (progress_q.size() != 0 || frame_uv_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic load_atlas(input logic [7:0] ty, input logic [3:0] rd,
                            input logic [63:0] cols);
    reg_write(REG_TILES_Y, {56'd0, ty});
    reg_write(REG_ROWS_DEF, {60'd0, rd});
    reg_write(REG_ROW_COLS, cols);
  endtask

  // progress mix: mostly in range, some at the edges and above 1.0
  function automatic logic [UvW-1:0] pick_progress();
    case ($urandom_range(9))
      0: return OneQ;
      1: return UvW'($urandom_range(17'h1FFFF, 17'h10001));
      2: return UvW'($urandom_range(3));
      default: return UvW'($urandom_range(32'(OneQ) - 1));
    endcase
  endfunction

  function automatic logic [63:0] pick_cols();
    logic [63:0] v;
    for (int i = 0; i < 8; i++)
      case ($urandom_range(5))
        0: v[i*8 +: 8] = 8'd0;
        1: v[i*8 +: 8] = 8'hFF;
        2: v[i*8 +: 8] = 8'($urandom);
        default: v[i*8 +: 8] = 8'($urandom_range(1, 12));
      endcase
    return v;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset atlas, progress edges
    progress_q = '{17'd0, 17'd1, 17'hFFFF, OneQ, 17'h1FFFF, 17'h10001};
    wait_drained();
    // mixed rows, 8 rows in use, zero and 255-wide rows
    load_atlas(8'd8, 4'd8, 64'hFF00_0302_0104_05FF);
    progress_q = '{17'd0, 17'd256, 17'h4000, 17'h8000, 17'hC000, 17'hFFFF, OneQ,
                   17'h1FFFF};
    wait_drained();
    // rows_defined above max saturates; tiles_y 0 treated as 1
    load_atlas(8'd0, 4'd15, 64'h0807_0605_0403_0201);
    progress_q = '{17'd0, 17'hAAAA, OneQ};
    wait_drained();
    // no rows in use; tiles_y 255
    load_atlas(8'd255, 4'd0, '1);
    progress_q = '{17'd0, 17'h5555, OneQ, 17'h1FFFF};
    wait_drained();
    // unknown register index is ignored
    reg_write(REG_NONE, '1);
    progress_q.push_back(17'h8000);
    wait_drained();

    // random phases, atlas reloaded between them
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: send_idle_pct = 0;
        1: send_idle_pct = 76;
        2: send_idle_pct = 22;
        default: send_idle_pct = $urandom_range(50);
      endcase
      case (ph % 5)
        0: load_atlas(8'($urandom), 4'($urandom), pick_cols());
        1: load_atlas(8'($urandom_range(1, 8)), 4'($urandom_range(1, 8)), pick_cols());
        2: load_atlas(8'd255, 4'd8, '1);
        3: load_atlas(8'd1, 4'd1, 64'd0);
        default: load_atlas(8'($urandom_range(8)), 4'($urandom_range(9, 15)),
                            pick_cols());
      endcase
      for (int i = 0; i < 50; i++) progress_q.push_back(pick_progress());
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/afuv_pkg.sv
hw/rtl/afuv_cfg.sv
hw/rtl/afuv_front.sv
hw/rtl/afuv_div.sv
hw/rtl/flipbook_atlas_frame_uv.sv
dv/tb.sv
